// File: rtl/rd_pkg.sv
package rd_pkg;

    localparam int ETA_W      = 20;
    localparam int COS_W      = 29;
    localparam int DIV_STEPS  = 20;
    localparam int SQRT_STEPS = 27;

    localparam logic [ETA_W-1:0]   ETA_MAX   = 20'hFFFFF;
    localparam logic signed [15:0] Q_ONE_OUT = 16'sd16384;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [15:0]        index_of_refraction;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic               total_reflection;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic [ETA_W-1:0]   eta;
        logic [COS_W-1:0]   cosq;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [16:0] norm_x;
        logic signed [16:0] norm_y;
        logic signed [16:0] norm_z;
    } t_mid_item;

endpackage

// File: rtl/rd_fifo.sv
module rd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rd_pkg::t_mid_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output rd_pkg::t_mid_item o_item
);
    import rd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_mid_item     r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: rtl/rd_front.sv
module rd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rd_pkg::t_in_item  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output rd_pkg::t_mid_item o_item
);
    import rd_pkg::*;

    typedef struct packed {
        logic               entering;
        logic               sat;
        logic [15:0]        ior;
        logic [15:0]        rem;
        logic [ETA_W-1:0]   q;
        logic [COS_W-1:0]   cosq;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } t_div;

    localparam logic signed [33:0] ONE_DOT = 34'sd268435456;

    logic               en;
    logic               r_va;
    logic signed [31:0] r_px, r_py, r_pz;
    t_in_item           r_a;
    logic signed [33:0] dot, dotc;
    t_div               n_d0;
    t_div               r_d [0:DIV_STEPS];
    t_div               n_d [1:DIV_STEPS];
    logic [16:0]        sh  [1:DIV_STEPS];
    logic [DIV_STEPS:0] r_vd;
    t_mid_item          r_q, n_q;
    logic               r_vq;

    assign en      = !r_vq || i_ready;
    assign o_ready = en;
    assign o_valid = r_vq;
    assign o_item  = r_q;

    // dot product, clamp, direction class
    always_comb begin
        dot = 34'(r_px) + 34'(r_py) + 34'(r_pz);
        if (dot > ONE_DOT) begin
            dotc = ONE_DOT;
        end else if (dot < -ONE_DOT) begin
            dotc = -ONE_DOT;
        end else begin
            dotc = dot;
        end
        n_d0.entering = dotc < 0;
        n_d0.cosq     = n_d0.entering ? COS_W'(-dotc) : COS_W'(dotc);
        // 2^28/ior reaches 2^20 at ior <= 256, zero index included
        n_d0.sat      = r_a.index_of_refraction <= 16'd256;
        n_d0.ior      = r_a.index_of_refraction;
        n_d0.rem      = 16'd256;
        n_d0.q        = '0;
        n_d0.dx       = r_a.dir_x;
        n_d0.dy       = r_a.dir_y;
        n_d0.dz       = r_a.dir_z;
        n_d0.nx       = r_a.norm_x;
        n_d0.ny       = r_a.norm_y;
        n_d0.nz       = r_a.norm_z;
    end

    // restoring divide of 2^28 by ior, one quotient bit per stage
    always_comb begin
        for (int j = 1; j <= DIV_STEPS; j++) begin
            sh[j]  = {r_d[j-1].rem, 1'b0};
            n_d[j] = r_d[j-1];
            if (sh[j] >= {1'b0, r_d[j-1].ior}) begin
                n_d[j].rem = 16'(sh[j] - {1'b0, r_d[j-1].ior});
                n_d[j].q   = {r_d[j-1].q[ETA_W-2:0], 1'b1};
            end else begin
                n_d[j].rem = sh[j][15:0];
                n_d[j].q   = {r_d[j-1].q[ETA_W-2:0], 1'b0};
            end
        end
    end

    // pick eta, flip normal on exit
    always_comb begin
        if (!r_d[DIV_STEPS].entering) begin
            n_q.eta    = {r_d[DIV_STEPS].ior, 4'b0000};
            n_q.norm_x = -17'($signed(r_d[DIV_STEPS].nx));
            n_q.norm_y = -17'($signed(r_d[DIV_STEPS].ny));
            n_q.norm_z = -17'($signed(r_d[DIV_STEPS].nz));
        end else begin
            n_q.eta    = r_d[DIV_STEPS].sat ? ETA_MAX : r_d[DIV_STEPS].q;
            n_q.norm_x = 17'($signed(r_d[DIV_STEPS].nx));
            n_q.norm_y = 17'($signed(r_d[DIV_STEPS].ny));
            n_q.norm_z = 17'($signed(r_d[DIV_STEPS].nz));
        end
        n_q.cosq  = r_d[DIV_STEPS].cosq;
        n_q.dir_x = r_d[DIV_STEPS].dx;
        n_q.dir_y = r_d[DIV_STEPS].dy;
        n_q.dir_z = r_d[DIV_STEPS].dz;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a    <= i_data;
            r_px   <= i_data.dir_x * i_data.norm_x;
            r_py   <= i_data.dir_y * i_data.norm_y;
            r_pz   <= i_data.dir_z * i_data.norm_z;
            r_d[0] <= n_d0;
            for (int j = 1; j <= DIV_STEPS; j++) begin
                r_d[j] <= n_d[j];
            end
            r_q    <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vd <= '0;
            r_vq <= 1'b0;
        end else if (en) begin
            r_va <= i_valid;
            r_vd <= {r_vd[DIV_STEPS-1:0], r_va};
            r_vq <= r_vd[DIV_STEPS];
        end
    end

endmodule

// File: rtl/rd_back.sv
module rd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rd_pkg::t_mid_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output rd_pkg::t_out_item o_data
);
    import rd_pkg::*;

    typedef struct packed {
        t_mid_item   item;
        logic        tir;
        logic [30:0] ecos;
        logic [53:0] v;
        logic [27:0] rem;
        logic [SQRT_STEPS-1:0] q;
    } t_sq;

    localparam int NV = SQRT_STEPS + 5;

    logic        en;
    logic [NV:0] r_v;

    t_mid_item   r_c_item;
    logic [57:0] r_cos2;
    logic [39:0] r_eta2;

    t_mid_item   r_m_item;
    logic [40:0] r_hi, r_lo;
    logic [48:0] r_ecos;
    logic [57:0] t_sin;
    logic [20:0] sin2;

    logic [60:0] prod;
    t_sq         n_s0;
    t_sq         r_s [0:SQRT_STEPS];
    t_sq         n_s [1:SQRT_STEPS];
    logic [29:0] r2  [1:SQRT_STEPS];
    logic [29:0] trial [1:SQRT_STEPS];

    t_mid_item          r_e_item;
    logic               r_e_tir;
    logic signed [32:0] r_coef;

    logic               r_f_tir;
    logic signed [36:0] r_pdx, r_pdy, r_pdz;
    logic signed [49:0] r_pnx, r_pny, r_pnz;

    t_out_item r_out, n_out;

    function automatic logic signed [15:0] sat_out(input logic signed [36:0] pd,
                                                   input logic signed [49:0] pn);
        logic signed [51:0] sum;
        logic signed [51:0] rnd;
        sum = ($signed(52'(pd)) <<< 10) + 52'(pn);
        rnd = (sum + 52'sd33554432) >>> 26;
        if (rnd > 52'sd32767) begin
            return 16'sh7FFF;
        end else if (rnd < -52'sd32768) begin
            return 16'sh8000;
        end
        return rnd[15:0];
    endfunction

    assign en      = !r_v[NV] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[NV];
    assign o_data  = r_out;

    always_comb begin
        t_sin = 58'h100000000000000 - r_cos2;
        sin2  = t_sin[56:36];
    end

    // k = 2^52 - eta^2 * sin^2, sign tells total reflection
    always_comb begin
        prod        = {r_hi, 20'b0} + 61'(r_lo);
        n_s0.item   = r_m_item;
        n_s0.tir    = prod > 61'h10000000000000;
        n_s0.ecos   = r_ecos[48:18];
        n_s0.v      = {1'b0, 53'(61'h10000000000000 - prod)};
        n_s0.rem    = '0;
        n_s0.q      = '0;
    end

    // integer square root, one root bit per stage
    always_comb begin
        for (int i = 1; i <= SQRT_STEPS; i++) begin
            r2[i]    = {r_s[i-1].rem, r_s[i-1].v[2*(SQRT_STEPS-i) +: 2]};
            trial[i] = {1'b0, r_s[i-1].q, 2'b01};
            n_s[i]   = r_s[i-1];
            if (r2[i] >= trial[i]) begin
                n_s[i].rem = 28'(r2[i] - trial[i]);
                n_s[i].q   = {r_s[i-1].q[SQRT_STEPS-2:0], 1'b1};
            end else begin
                n_s[i].rem = r2[i][27:0];
                n_s[i].q   = {r_s[i-1].q[SQRT_STEPS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_f_tir) begin
            n_out.out_x = Q_ONE_OUT;
            n_out.out_y = '0;
            n_out.out_z = '0;
        end else begin
            n_out.out_x = sat_out(r_pdx, r_pnx);
            n_out.out_y = sat_out(r_pdy, r_pny);
            n_out.out_z = sat_out(r_pdz, r_pnz);
        end
        n_out.total_reflection = r_f_tir;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_item <= i_item;
            r_cos2   <= i_item.cosq * i_item.cosq;
            r_eta2   <= i_item.eta * i_item.eta;

            r_m_item <= r_c_item;
            r_hi     <= r_eta2[39:20] * sin2;
            r_lo     <= r_eta2[19:0] * sin2;
            r_ecos   <= r_c_item.eta * r_c_item.cosq;

            r_s[0]   <= n_s0;
            for (int i = 1; i <= SQRT_STEPS; i++) begin
                r_s[i] <= n_s[i];
            end

            r_e_item <= r_s[SQRT_STEPS].item;
            r_e_tir  <= r_s[SQRT_STEPS].tir;
            r_coef   <= $signed({2'b00, r_s[SQRT_STEPS].ecos})
                        - $signed({6'b0, r_s[SQRT_STEPS].q});

            r_f_tir  <= r_e_tir;
            r_pdx    <= $signed({1'b0, r_e_item.eta}) * r_e_item.dir_x;
            r_pdy    <= $signed({1'b0, r_e_item.eta}) * r_e_item.dir_y;
            r_pdz    <= $signed({1'b0, r_e_item.eta}) * r_e_item.dir_z;
            r_pnx    <= r_coef * r_e_item.norm_x;
            r_pny    <= r_coef * r_e_item.norm_y;
            r_pnz    <= r_coef * r_e_item.norm_z;

            r_out    <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NV-1:0], i_valid};
        end
    end

endmodule

// File: rtl/refraction_direction.sv
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_data  (dir, normal, index)
// out       output     o_out_valid / i_out_ready  o_out_data (refracted dir, flag)
//
// One item per cycle sustained while neither front nor back stalls. The front
// does the dot product, clamp and 20-stage divider for 1/ior; items then pass
// the queue; the back does k, 27-stage square root, final multiply and round.
// Reset is synchronous, active low, and empties both pipelines and the queue.
// Front and back each stall as a whole: the front when the queue is full,
// the back when a finished item is not taken.
module refraction_direction #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rd_pkg::t_in_item  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rd_pkg::t_out_item o_out_data
);
    import rd_pkg::*;

    // front -> queue
    logic      f_valid, f_ready;
    t_mid_item f_item;
    // queue -> back
    logic      q_valid, q_ready;
    t_mid_item q_item;

    // front: classify entering/exiting, build eta, orient normal
    rd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    // short queue decouples front stalls from back stalls
    rd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    // back: k, sqrt, combine, round and saturate
    rd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// File: rtl/rd_checker.sv
module rd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input rd_pkg::t_in_item  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input rd_pkg::t_out_item o_out_data
);
    import rd_pkg::*;

    logic [7:0] r_cnt;

    // items inside the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 8'(i_in_valid && o_in_ready) - 8'(o_out_valid && i_out_ready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_tir_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.total_reflection |->
            o_out_data.out_x == Q_ONE_OUT && o_out_data.out_y == '0
            && o_out_data.out_z == '0)
        else $error("total reflection result is not (1,0,0)");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != '0)
        else $error("result without an accepted item");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind refraction_direction rd_checker u_rd_checker (.*);
